@@ src/gdrm_pkg.sv @@
`default_nettype none

package gdrm_pkg;

    // Default array limits
    localparam int DEF_MAX_GRID_W = 64;
    localparam int DEF_MAX_GRID_H = 64;
    localparam int DEF_MAX_RADIUS = 31;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 5;
    localparam int GDIM_W    = 7;
    localparam int CSIZE_W   = 16;
    localparam int FOG_W     = 2;
    localparam int OP_W      = 2;
    localparam int CELL_W    = COORD_W + 1;      // floor quotient, signed
    localparam int IDX_W     = 2 * GDIM_W;       // row * width + column
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Register reset values
    localparam logic [GDIM_W-1:0]  RST_GRID_W    = 7'd64;
    localparam logic [GDIM_W-1:0]  RST_GRID_H    = 7'd64;
    localparam logic [CSIZE_W-1:0] RST_CELL_SIZE = 16'd100;

    // Cell states
    localparam logic [FOG_W-1:0] FOG_UNEXPLORED = 2'd0;
    localparam logic [FOG_W-1:0] FOG_PARTIAL    = 2'd1;
    localparam logic [FOG_W-1:0] FOG_EXPLORED   = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_REVEAL = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_GRID_W    = 2'd0,
        REG_GRID_H    = 2'd1,
        REG_CELL_SIZE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GDIM_W-1:0]  grid_w;
        logic [GDIM_W-1:0]  grid_h;
        logic [CSIZE_W-1:0] cell_size;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_write;
        logic set_ready;
        logic div_start;
        logic div_sel_y;
        logic latch_x;
        logic latch_y;
        logic scan_addr;
        logic scan_read;
        logic scan_write;
        logic q_cap;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic map_ready;
        logic div_done;
        logic clr_last;
        logic scan_last;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/gdrm_div.sv @@
`default_nettype none

module gdrm_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [gdrm_pkg::COORD_W-1:0] dividend,
    input  wire logic [gdrm_pkg::CSIZE_W-1:0]        divisor,
    output logic                                     done,
    output logic signed [gdrm_pkg::CELL_W-1:0]       quotient
);
    import gdrm_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic                      run_reg;
    logic                      fix_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [COORD_W-1:0]        mag_reg;
    logic [CSIZE_W-1:0]        rem_reg;
    logic [CSIZE_W-1:0]        dvs_reg;
    logic                      neg_reg;
    logic signed [CELL_W-1:0]  quot_reg;

    logic [CSIZE_W:0]          trial;
    logic                      ge;
    logic [CSIZE_W:0]          diff;
    logic signed [CELL_W-1:0]  pos_q;

    // One restoring step per cycle on the magnitude
    always_comb
    begin
        trial = {rem_reg, mag_reg[COORD_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
        pos_q = $signed({1'b0, mag_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COORD_W - 1))
                begin
                    run_reg <= 1'b0;
                    fix_reg <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Payload: magnitude, remainder, sign fix-up toward minus infinity
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend[COORD_W-1] ? COORD_W'(-dividend) : COORD_W'(dividend);
            neg_reg <= dividend[COORD_W-1];
            rem_reg <= '0;
            dvs_reg <= (divisor == '0) ? CSIZE_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[CSIZE_W-1:0] : trial[CSIZE_W-1:0];
            mag_reg <= {mag_reg[COORD_W-2:0], ge};
        end
        if (fix_reg)
        begin
            if (neg_reg)
                quot_reg <= -pos_q - $signed({{(CELL_W-1){1'b0}}, rem_reg != '0});
            else
                quot_reg <= pos_q;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

@@ src/gdrm_dp.sv @@
`default_nettype none

module gdrm_dp #(
    parameter int MAX_GRID_W = gdrm_pkg::DEF_MAX_GRID_W,
    parameter int MAX_GRID_H = gdrm_pkg::DEF_MAX_GRID_H,
    parameter int MAX_RADIUS = gdrm_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gdrm_pkg::cfg_t                    cfg,
    input  wire gdrm_pkg::dp_cmd_t                 cmd,
    output gdrm_pkg::dp_status_t                   st,
    input  wire logic [gdrm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic [gdrm_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [gdrm_pkg::M_TDATA_W-1:0]         m_axis_tdata
);
    import gdrm_pkg::*;

    localparam int CELLS = MAX_GRID_W * MAX_GRID_H;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SW    = CELL_W + 1;   // cell coordinate plus offset

    // Request fields
    op_t                        op_reg;
    logic signed [COORD_W-1:0]  wx_reg;
    logic signed [COORD_W-1:0]  wy_reg;
    logic [RAD_W-1:0]           rr_reg;
    logic                       full_reg;
    logic                       map_ready_reg;

    // Clear sweep, centre cell and disc scan
    logic [AW-1:0]              clr_cnt_reg;
    logic signed [CELL_W-1:0]   cx_reg;
    logic signed [CELL_W-1:0]   cy_reg;
    logic signed [RAD_W:0]      dx_reg;
    logic signed [RAD_W:0]      dy_reg;
    logic                       cell_ok_reg;
    logic [GDIM_W-1:0]          cellx_reg;
    logic [GDIM_W-1:0]          celly_reg;
    logic [AW-1:0]              addr_reg;
    logic [FOG_W-1:0]           rdata_reg;

    // Result and output stage
    logic [FOG_W-1:0]           res_fog_reg;
    logic                       res_in_reg;
    logic                       out_valid_reg;
    logic [3:0]                 out_data_reg;

    logic [FOG_W-1:0]           mem [CELLS];

    logic [GDIM_W-1:0]          eff_w;
    logic [GDIM_W-1:0]          eff_h;
    logic [RAD_W-1:0]           in_rad;
    logic signed [RAD_W:0]      rr_s;
    logic signed [SW-1:0]       sx;
    logic signed [SW-1:0]       sy;
    logic                       in_x;
    logic                       in_y;
    logic [RAD_W-1:0]           adx;
    logic [RAD_W-1:0]           ady;
    logic [2*RAD_W:0]           dist2;
    logic [2*RAD_W:0]           rad2;
    logic [IDX_W-1:0]           idx;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [FOG_W-1:0]           wr_data;
    logic                       div_done;
    logic signed [CELL_W-1:0]   div_q;

    gdrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_y ? wy_reg : wx_reg),
        .divisor  (cfg.cell_size),
        .done     (div_done),
        .quotient (div_q)
    );

    // Effective geometry and radius
    always_comb
    begin
        eff_w  = (int'(cfg.grid_w) > MAX_GRID_W) ? GDIM_W'(MAX_GRID_W) : cfg.grid_w;
        eff_h  = (int'(cfg.grid_h) > MAX_GRID_H) ? GDIM_W'(MAX_GRID_H) : cfg.grid_h;
        in_rad = s_axis_tdata[2*COORD_W +: RAD_W];
        if (int'(in_rad) > MAX_RADIUS)
            in_rad = RAD_W'(MAX_RADIUS);
        rr_s   = $signed({1'b0, rr_reg});
    end

    // Cell under the current offset: grid bounds and disc test
    always_comb
    begin
        sx    = SW'(cx_reg) + SW'(dx_reg);
        sy    = SW'(cy_reg) + SW'(dy_reg);
        in_x  = !sx[SW-1] && (sx < $signed({{(SW-GDIM_W){1'b0}}, eff_w}));
        in_y  = !sy[SW-1] && (sy < $signed({{(SW-GDIM_W){1'b0}}, eff_h}));
        adx   = dx_reg[RAD_W] ? RAD_W'(-dx_reg) : RAD_W'(dx_reg);
        ady   = dy_reg[RAD_W] ? RAD_W'(-dy_reg) : RAD_W'(dy_reg);
        dist2 = (2*RAD_W+1)'(adx) * (2*RAD_W+1)'(adx)
              + (2*RAD_W+1)'(ady) * (2*RAD_W+1)'(ady);
        rad2  = (2*RAD_W+1)'(rr_reg) * (2*RAD_W+1)'(rr_reg);
        idx   = IDX_W'(celly_reg) * IDX_W'(eff_w) + IDX_W'(cellx_reg);
    end

    // Write port: clear sweep or reveal update
    always_comb
    begin
        if (cmd.clr_write)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = FOG_UNEXPLORED;
        end
        else
        begin
            wr_en   = cmd.scan_write && cell_ok_reg
                      && (full_reg || rdata_reg == FOG_UNEXPLORED);
            wr_addr = addr_reg;
            wr_data = full_reg ? FOG_EXPLORED : FOG_PARTIAL;
        end
    end

    // Cell state memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.scan_read)
            rdata_reg <= mem[AW'(idx)];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_ready)
                map_ready_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(s_axis_tuser);
            wx_reg      <= $signed(s_axis_tdata[0 +: COORD_W]);
            wy_reg      <= $signed(s_axis_tdata[COORD_W +: COORD_W]);
            rr_reg      <= (op_t'(s_axis_tuser) == OP_REVEAL) ? in_rad : '0;
            full_reg    <= s_axis_tdata[2*COORD_W + RAD_W];
            clr_cnt_reg <= '0;
            res_fog_reg <= FOG_UNEXPLORED;
            res_in_reg  <= 1'b0;
        end
        if (cmd.clr_write)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        if (cmd.latch_x)
            cx_reg <= div_q;
        if (cmd.latch_y)
        begin
            cy_reg <= div_q;
            dx_reg <= -rr_s;
            dy_reg <= -rr_s;
        end
        if (cmd.scan_addr)
        begin
            cell_ok_reg <= in_x && in_y && (dist2 <= rad2);
            cellx_reg   <= sx[GDIM_W-1:0];
            celly_reg   <= sy[GDIM_W-1:0];
        end
        if (cmd.scan_read)
            addr_reg <= AW'(idx);
        // Raster step through the bounding square
        if (cmd.scan_write)
        begin
            if (dx_reg == rr_s)
            begin
                dx_reg <= -rr_s;
                dy_reg <= dy_reg + 1'b1;
            end
            else
                dx_reg <= dx_reg + 1'b1;
        end
        if (cmd.q_cap)
        begin
            res_in_reg  <= cell_ok_reg;
            res_fog_reg <= cell_ok_reg ? rdata_reg : FOG_UNEXPLORED;
        end
        if (cmd.out_load)
            out_data_reg <= {res_in_reg, res_fog_reg != FOG_UNEXPLORED, res_fog_reg};
    end

    always_comb
    begin
        st.op        = op_reg;
        st.map_ready = map_ready_reg;
        st.div_done  = div_done;
        st.clr_last  = (clr_cnt_reg == AW'(CELLS - 1));
        st.scan_last = (dx_reg == rr_s) && (dy_reg == rr_s);
        st.out_busy  = out_valid_reg && !m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-4)'(0), out_data_reg};

    // Once cleared the map stays ready
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(map_ready_reg))
        else $error("map ready dropped");

    // Memory is only written by a clear or a reveal
    a_write_op: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (op_reg == OP_CLEAR || op_reg == OP_REVEAL))
        else $error("cell write outside clear or reveal");

    // A hit can only be reported by a ready map
    a_hit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[3]) |-> map_ready_reg)
        else $error("in_grid set before first clear");

endmodule

`default_nettype wire

@@ src/gdrm_ctrl.sv @@
`default_nettype none

module gdrm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire gdrm_pkg::dp_status_t st,
    output gdrm_pkg::dp_cmd_t         cmd
);
    import gdrm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_SC_ADDR,
        S_SC_READ,
        S_SC_WRITE,
        S_Q_CAP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_axis_tvalid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                case (st.op)
                    OP_CLEAR:  state_next = S_CLEAR;
                    OP_REVEAL: state_next = st.map_ready ? S_DIVX_GO : S_DONE;
                    OP_QUERY:  state_next = st.map_ready ? S_DIVX_GO : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            S_CLEAR:
                if (st.clr_last)
                    state_next = S_DONE;
            S_DIVX_GO:
                state_next = S_DIVX_WAIT;
            S_DIVX_WAIT:
                if (st.div_done)
                    state_next = S_DIVY_GO;
            S_DIVY_GO:
                state_next = S_DIVY_WAIT;
            S_DIVY_WAIT:
                if (st.div_done)
                    state_next = S_SC_ADDR;
            S_SC_ADDR:
                state_next = S_SC_READ;
            S_SC_READ:
                state_next = (st.op == OP_QUERY) ? S_Q_CAP : S_SC_WRITE;
            S_SC_WRITE:
                state_next = st.scan_last ? S_DONE : S_SC_ADDR;
            S_Q_CAP:
                state_next = S_DONE;
            S_DONE:
                if (!st.out_busy)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands decoded from state
    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == S_IDLE) && s_axis_tvalid;
        cmd.clr_write  = (state_reg == S_CLEAR);
        cmd.set_ready  = (state_reg == S_CLEAR) && st.clr_last;
        cmd.div_start  = (state_reg == S_DIVX_GO) || (state_reg == S_DIVY_GO);
        cmd.div_sel_y  = (state_reg == S_DIVY_GO);
        cmd.latch_x    = (state_reg == S_DIVX_WAIT) && st.div_done;
        cmd.latch_y    = (state_reg == S_DIVY_WAIT) && st.div_done;
        cmd.scan_addr  = (state_reg == S_SC_ADDR);
        cmd.scan_read  = (state_reg == S_SC_READ);
        cmd.scan_write = (state_reg == S_SC_WRITE);
        cmd.q_cap      = (state_reg == S_Q_CAP);
        cmd.out_load   = (state_reg == S_DONE) && !st.out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // Divider completes only while a wait state expects it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == S_DIVX_WAIT || state_reg == S_DIVY_WAIT))
        else $error("divider done outside wait state");

    // The clear sweep runs only for a clear request
    a_clear_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (st.op == OP_CLEAR))
        else $error("clear sweep for another request");

    // An accepted request is dispatched in the next cycle
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

endmodule

`default_nettype wire

@@ src/grid_disc_reveal_map.sv @@
// Fog map of up to MAX_GRID_W x MAX_GRID_H cells of two bits each. One request
// is taken at a time on the input stream and gives exactly one result. A clear
// sweeps the cell memory one entry per cycle; the map is ready after the first
// clear. A reveal or query first runs two floor divisions of the world point by
// cell_size through one bit-serial divider. A reveal then walks the (2R+1)^2
// square around the centre cell with an offset test, a memory read and a memory
// write per cell. Requests before the first clear, and the unused op, give a
// zero result without touching the map.
// The cell memory has one write and one read port.
// The result waits in an output register, so a new request is accepted while
// it is still pending.
`default_nettype none

module grid_disc_reveal_map #(
    parameter int MAX_GRID_W = gdrm_pkg::DEF_MAX_GRID_W,
    parameter int MAX_GRID_H = gdrm_pkg::DEF_MAX_GRID_H,
    parameter int MAX_RADIUS = gdrm_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Request stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // world_x[31:0], world_y[63:32], radius[68:64], full_reveal[69], zero[71:70]
    input  wire logic [gdrm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [gdrm_pkg::OP_W-1:0]      s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // fog_state[1:0], is_explored[2], in_grid[3], zero[7:4]
    output logic [gdrm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gdrm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [gdrm_pkg::PDATA_W-1:0]   pwdata,
    output logic [gdrm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import gdrm_pkg::*;

    logic [GDIM_W-1:0]  grid_w_reg;
    logic [GDIM_W-1:0]  grid_h_reg;
    logic [CSIZE_W-1:0] cell_size_reg;
    reg_idx_t           reg_idx;
    logic               wr_req;
    cfg_t               cfg;
    dp_cmd_t            cmd;
    dp_status_t         st;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_req  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg    <= RST_GRID_W;
            grid_h_reg    <= RST_GRID_H;
            cell_size_reg <= RST_CELL_SIZE;
        end
        else if (wr_req)
        begin
            case (reg_idx)
                REG_GRID_W:    grid_w_reg    <= pwdata[GDIM_W-1:0];
                REG_GRID_H:    grid_h_reg    <= pwdata[GDIM_W-1:0];
                REG_CELL_SIZE: cell_size_reg <= pwdata[CSIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_GRID_W:    prdata = PDATA_W'(grid_w_reg);
            REG_GRID_H:    prdata = PDATA_W'(grid_h_reg);
            REG_CELL_SIZE: prdata = PDATA_W'(cell_size_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.grid_w    = grid_w_reg;
    assign cfg.grid_h    = grid_h_reg;
    assign cfg.cell_size = cell_size_reg;

    gdrm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    gdrm_dp #(
        .MAX_GRID_W (MAX_GRID_W),
        .MAX_GRID_H (MAX_GRID_H),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .st            (st),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ dv/grid_disc_reveal_map_tb.sv @@
`default_nettype none

module grid_disc_reveal_map_tb;

    import gdrm_pkg::*;

    localparam int MAP_W       = DEF_MAX_GRID_W;
    localparam int MAP_H       = DEF_MAX_GRID_H;
    localparam int RAD_MAX     = DEF_MAX_RADIUS;
    localparam int HOLD_LEN    = 3000;
    localparam int STUCK_LIMIT = 60000;

    typedef struct packed {
        logic [FOG_W-1:0] fog;
        logic             explored;
        logic             in_grid;
    } fog_reply_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Predicted map state and register copies
    logic [FOG_W-1:0]   fog_map [0:MAP_W*MAP_H-1];
    bit                 map_live   = 1'b0;
    logic [GDIM_W-1:0]  width_reg  = RST_GRID_W;
    logic [GDIM_W-1:0]  height_reg = RST_GRID_H;
    logic [CSIZE_W-1:0] size_reg   = RST_CELL_SIZE;

    fog_reply_t pending_replies[$];
    fog_reply_t want;

    int  mismatches      = 0;
    int  replies_checked = 0;
    int  reg_writes      = 0;
    int  op_seen[4]      = '{0, 0, 0, 0};
    int  stuck_cycles    = 0;
    int  stall_left      = 0;
    int  sink_gap;
    bit  quiet           = 1'b0;
    bit  hold_request    = 1'b0;

    grid_disc_reveal_map i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, longint got, longint exp);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
        mismatches++;
    endtask

    // Mostly short gaps, some medium, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic longint eff_width();
        return (width_reg > MAP_W) ? longint'(MAP_W) : longint'(width_reg);
    endfunction

    function automatic longint eff_height();
        return (height_reg > MAP_H) ? longint'(MAP_H) : longint'(height_reg);
    endfunction

    function automatic longint eff_cell_size();
        return (size_reg == 0) ? 64'sd1 : longint'(size_reg);
    endfunction

    // Division rounding toward minus infinity
    function automatic longint floor_quot(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q--;
        return q;
    endfunction

    // Storage slot of a cell, -1 when outside the grid in use
    function automatic int map_slot(longint cx, longint cy);
        longint w;
        longint h;
        w = eff_width();
        h = eff_height();
        if (cx < 0 || cx >= w || cy < 0 || cy >= h)
            return -1;
        return int'(cy * w + cx);
    endfunction

    // Updates the predicted map for one request and returns its expected reply
    function automatic fog_reply_t apply_request(op_t op, logic signed [31:0] wx,
                                                 logic signed [31:0] wy, logic [4:0] rad,
                                                 logic full);
        fog_reply_t rep;
        longint     cs;
        longint     cx;
        longint     cy;
        longint     rr;
        int         slot;
        rep = '0;
        cs  = eff_cell_size();
        cx  = floor_quot(longint'(wx), cs);
        cy  = floor_quot(longint'(wy), cs);
        case (op)
            OP_CLEAR:
            begin
                foreach (fog_map[i])
                    fog_map[i] = FOG_UNEXPLORED;
                map_live = 1'b1;
            end
            OP_REVEAL:
            begin
                if (map_live)
                begin
                    rr = (rad > RAD_MAX) ? longint'(RAD_MAX) : longint'(rad);
                    for (longint dy = -rr; dy <= rr; dy++)
                    begin
                        for (longint dx = -rr; dx <= rr; dx++)
                        begin
                            if (dx * dx + dy * dy <= rr * rr)
                            begin
                                slot = map_slot(cx + dx, cy + dy);
                                if (slot >= 0)
                                begin
                                    if (full)
                                        fog_map[slot] = FOG_EXPLORED;
                                    else if (fog_map[slot] == FOG_UNEXPLORED)
                                        fog_map[slot] = FOG_PARTIAL;
                                end
                            end
                        end
                    end
                end
            end
            OP_QUERY:
            begin
                if (map_live)
                begin
                    slot = map_slot(cx, cy);
                    if (slot >= 0)
                    begin
                        rep.fog      = fog_map[slot];
                        rep.explored = (fog_map[slot] != FOG_UNEXPLORED);
                        rep.in_grid  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Offers one request, waits for it to be taken, then idles a random gap.
    // Called and returns at a falling edge.
    task automatic send_request(op_t op, logic signed [31:0] wx, logic signed [31:0] wy,
                                logic [4:0] rad, logic full);
        int gap;
        s_axis_tdata  <= {2'b00, full, rad, wy, wx};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_replies.push_back(apply_request(op, wx, wy, rad, full));
        op_seen[op]++;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stops offering and waits for every pending reply
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register write followed by a read-back
    task automatic program_reg(reg_idx_t idx, logic [31:0] val);
        logic [31:0] kept;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_GRID_W:    width_reg  = val[GDIM_W-1:0];
            REG_GRID_H:    height_reg = val[GDIM_W-1:0];
            REG_CELL_SIZE: size_reg   = val[CSIZE_W-1:0];
            default: ;
        endcase
        kept = (idx == REG_CELL_SIZE) ? 32'(size_reg)
             : (idx == REG_GRID_W)    ? 32'(width_reg) : 32'(height_reg);
        reg_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== kept)
            report_mismatch("register read-back", prdata, kept);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(logic [31:0] gw, logic [31:0] gh, logic [31:0] cs);
        drain();
        program_reg(REG_GRID_W, gw);
        program_reg(REG_GRID_H, gh);
        program_reg(REG_CELL_SIZE, cs);
    endtask

    // Random request, mostly aimed at or just around the grid in use
    task automatic random_request();
        op_t               op;
        int                p;
        longint            cs;
        longint            cx;
        longint            cy;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic [4:0]        rad;
        p  = $urandom_range(0, 99);
        op = (p < 3) ? OP_CLEAR : (p < 5) ? OP_NONE : (p < 50) ? OP_REVEAL : OP_QUERY;
        cs = eff_cell_size();
        if ($urandom_range(0, 99) < 85)
        begin
            cx = longint'($urandom_range(0, eff_width() + 3)) - 2;
            cy = longint'($urandom_range(0, eff_height() + 3)) - 2;
            wx = 32'(cx * cs + longint'($urandom_range(0, cs - 1)));
            wy = 32'(cy * cs + longint'($urandom_range(0, cs - 1)));
        end
        else
        begin
            wx = $urandom;
            wy = $urandom;
        end
        p = $urandom_range(0, 99);
        rad = (p < 70) ? 5'($urandom_range(0, 3))
            : (p < 97) ? 5'($urandom_range(4, 10)) : 5'($urandom_range(11, 31));
        send_request(op, wx, wy, rad, 1'($urandom_range(0, 1)));
    endtask

    // Reveals and queries before the map has ever been cleared
    task automatic test_before_clear();
        send_request(OP_QUERY, 150, 250, 0, 0);
        send_request(OP_REVEAL, 150, 250, 3, 1);
        send_request(OP_QUERY, 150, 250, 0, 0);
        send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1);
        send_request(OP_REVEAL, 0, 0, 31, 0);
        send_request(OP_QUERY, 0, 0, 0, 0);
        drain();
    endtask

    // Hand-picked requests at the default 64x64 grid with cell size 100
    task automatic test_directed();
        send_request(OP_CLEAR, 0, 0, 0, 0);
        send_request(OP_QUERY, 150, 250, 0, 0);
        send_request(OP_REVEAL, 150, 250, 0, 1);
        send_request(OP_QUERY, 199, 299, 0, 0);
        // partial ring, then full core, then partial again must not lower it
        send_request(OP_REVEAL, 3250, 3250, 2, 0);
        send_request(OP_QUERY, 3450, 3250, 0, 0);
        send_request(OP_QUERY, 3450, 3450, 0, 0);
        send_request(OP_REVEAL, 3250, 3250, 1, 1);
        send_request(OP_REVEAL, 3250, 3250, 2, 0);
        send_request(OP_QUERY, 3250, 3250, 0, 0);
        // centre just outside the corner, disc clipped by the grid
        send_request(OP_REVEAL, -1, -1, 31, 1);
        send_request(OP_QUERY, 0, 0, 0, 0);
        send_request(OP_QUERY, -1, 0, 0, 0);
        send_request(OP_QUERY, 6400, 0, 0, 0);
        send_request(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_request(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_request(OP_REVEAL, 6399, 6399, 31, 0);
        send_request(OP_QUERY, 6399, 6399, 0, 0);
        send_request(OP_QUERY, 6300, 0, 0, 0);
        send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        send_request(OP_QUERY, 0, 0, 0, 0);
        // stored cells read back under a narrower row pitch
        send_request(OP_REVEAL, 550, 550, 1, 1);
        drain();
        program_reg(REG_GRID_W, 10);
        send_request(OP_QUERY, 550, 550, 0, 0);
        send_request(OP_QUERY, 950, 500, 0, 0);
        drain();
        program_reg(REG_GRID_W, 64);
    endtask

    // Register extremes: one-cell grid, zero sizes, saturation, masking
    task automatic test_register_corners();
        logic [31:0] corner_cfg[7][3];
        corner_cfg = '{'{1, 1, 1}, '{64, 64, 65535}, '{127, 127, 0}, '{0, 9, 3},
                       '{9, 0, 3}, '{32'hFFFF_FF85, 37, 7}, '{100, 33, 32'hFFFF_0011}};
        foreach (corner_cfg[k])
        begin
            set_geometry(corner_cfg[k][0], corner_cfg[k][1], corner_cfg[k][2]);
            if (k == 2)
                send_request(OP_CLEAR, 0, 0, 0, 0);
            repeat (11) random_request();
        end
        drain();
    endtask

    // Result side held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_geometry(64, 64, 100);
        quiet        = 1'b1;
        hold_request = 1'b1;
        repeat (10) send_request(OP_QUERY, $urandom_range(0, 6399), $urandom_range(0, 6399), 0, 0);
        send_request(OP_REVEAL, 1000, 1000, 2, 1);
        send_request(OP_QUERY, 1000, 1000, 0, 0);
        quiet = 1'b0;
        drain();
    endtask

    // Random phases, each under its own register setting
    task automatic test_random();
        int p;
        logic [31:0] gw;
        logic [31:0] gh;
        logic [31:0] cs;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                gw = 64;
                gh = 64;
                cs = 100;
            end
            else
            begin
                p  = $urandom_range(0, 99);
                gw = (p < 10) ? 127 : (p < 20) ? 1 : (p < 25) ? 0 : $urandom_range(1, 64);
                p  = $urandom_range(0, 99);
                gh = (p < 10) ? 127 : (p < 20) ? 1 : (p < 25) ? 0 : $urandom_range(1, 64);
                p  = $urandom_range(0, 99);
                cs = (p < 10) ? 1 : (p < 15) ? 65535 : (p < 20) ? 0 : $urandom_range(2, 300);
            end
            set_geometry(gw, gh, cs);
            quiet = (phase == 3);
            repeat (57) random_request();
        end
        quiet = 1'b0;
        drain();
    endtask

    // Result side: random stalls plus the long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_LEN - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                sink_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (sink_gap > 0)
                begin
                    stall_left = sink_gap - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each reply with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("reply with no request pending", m_axis_tdata, 0);
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (m_axis_tdata[1:0] !== want.fog)
                    report_mismatch("fog_state", m_axis_tdata[1:0], want.fog);
                if (m_axis_tdata[2] !== want.explored)
                    report_mismatch("is_explored", m_axis_tdata[2], want.explored);
                if (m_axis_tdata[3] !== want.in_grid)
                    report_mismatch("in_grid", m_axis_tdata[3], want.in_grid);
            end
        end
    end

    // Ends the run when no handshake happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready))
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles, %0d replies pending",
                             stuck_cycles, pending_replies.size());
                    $display("grid_disc_reveal_map regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_before_clear();
        test_directed();
        test_register_corners();
        test_backpressure();
        test_random();

        drain();
        repeat (200) @(negedge clk);
        if (pending_replies.size() != 0)
            report_mismatch("replies never delivered", pending_replies.size(), 0);

        $display("Requests: %0d clears, %0d reveals, %0d queries, %0d unused op; %0d register writes",
                 op_seen[OP_CLEAR], op_seen[OP_REVEAL], op_seen[OP_QUERY], op_seen[OP_NONE],
                 reg_writes);
        $display("Replies checked: %0d, mismatches: %0d", replies_checked, mismatches);
        if (mismatches == 0)
            $display("grid_disc_reveal_map regression: pass");
        else
            $display("grid_disc_reveal_map regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/gdrm_pkg.sv
src/gdrm_div.sv
src/gdrm_dp.sv
src/gdrm_ctrl.sv
src/grid_disc_reveal_map.sv
dv/grid_disc_reveal_map_tb.sv
